FILE: rtl/core/ipap_pkg.sv
// Shared types, character codes and helpers for the IP address text parser.
// Used by every design module of the block (not by ipap_checker); depends on nothing.
package ipap_pkg;

	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_LEAD   = 3'd1,
		PH_GROUP  = 3'd2,
		PH_COLON  = 3'd3,
		PH_GAP    = 3'd4,
		PH_OCTET  = 3'd5,
		PH_IGNORE = 3'd6
	} ipap_phase_t;

	localparam logic [7:0]  CH_NUL     = 8'h00;
	localparam logic [7:0]  CH_COLON   = 8'h3a;
	localparam logic [7:0]  CH_DOT     = 8'h2e;
	localparam logic [8:0]  DEC_BAD    = 9'd256;
	localparam logic [8:0]  OCTET_MAX  = 9'd255;
	localparam logic [15:0] HEX_LIMIT  = 16'h0fff;
	localparam logic [15:0] GROUP_MAP  = 16'hffff;
	localparam logic [63:0] V4_MAP_LOW = 64'h0000_ffff_0000_0000;
	localparam logic [3:0]  GROUPS     = 4'd8;
	localparam logic [3:0]  GAP_GROUPS = 4'd7;
	localparam logic [2:0]  OCTETS     = 3'd4;

	// request from the input stage into the parser
	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
	} ipap_req_t;

	typedef struct packed {
		logic        ok;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
	} ipap_res_t;

	function automatic logic is_dec(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
			return {1'b1, v[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			v = c - 8'h37;
			return {1'b1, v[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
			return {1'b1, v[3:0]};
		end
		return 5'b0_0000;
	endfunction

endpackage

FILE: rtl/core/ipap_in_stage.sv
// Input register of the parser: holds one character request.
// Depends on ipap_pkg; lets a terminator wait while the result slot is busy.
module ipap_in_stage import ipap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [7:0] char_code,
	input  logic      out_busy,
	output logic      in_stall,
	output ipap_req_t req
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       fire;

	// only a terminator produces a result, so only it has to wait
	assign fire     = valid_s1 && ((char_s1 != CH_NUL) || !out_busy);
	assign in_stall = valid_s1 && !fire;

	assign req.valid     = fire;
	assign req.char_code = char_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_code;
		end
	end

endmodule

FILE: rtl/core/ipap_parse.sv
// Parser state and per-character update, plus result assembly on the terminator.
// Depends on ipap_pkg; holds the address family register.
module ipap_parse import ipap_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wen,
	input  logic      cfg_wdata,
	input  ipap_req_t req,
	output logic      res_valid,
	output ipap_res_t res
);

	logic          fam_q;
	ipap_phase_t   phase_q, phase_n;
	logic [3:0]    gcnt_q, gcnt_n;
	logic          gap_q, gap_n;
	logic [2:0]    gpos_q, gpos_n;
	logic [15:0]   hex_q, hex_n;
	logic [8:0]    dec_q, dec_n;
	logic [31:0]   oct_q, oct_n;
	logic [2:0]    ocnt_q, ocnt_n;
	logic          fail_q, fail_n;
	// groups before the gap shift into head, groups after it into tail
	logic [127:0]  head_q, head_n;
	logic [127:0]  tail_q, tail_n;

	logic [7:0]    c;
	logic          dig;
	logic [4:0]    hx;
	logic [11:0]   dec_mul;
	logic          do_octet;
	logic          term;

	logic [3:0]    fin_cnt;
	logic [127:0]  fin_head, fin_tail, head_sh, addr128;
	logic [3:0]    shamt;
	logic          v6_ok, oct_ok, fin_ok;
	logic [31:0]   oct_fin;
	logic [63:0]   fin_hi, fin_lo;

	assign c        = req.char_code;
	assign dig      = is_dec(c);
	assign hx       = hex_digit(c);
	assign dec_mul  = {3'b000, dec_q} * 12'd10 + {8'h00, c[3:0]};
	assign do_octet = fam_q ? (phase_q == PH_OCTET || phase_q == PH_IGNORE) : 1'b1;
	assign term     = req.valid && (c == CH_NUL);

	always_comb begin
		phase_n = phase_q;
		gcnt_n  = gcnt_q;
		gap_n   = gap_q;
		gpos_n  = gpos_q;
		hex_n   = hex_q;
		dec_n   = dec_q;
		oct_n   = oct_q;
		ocnt_n  = ocnt_q;
		fail_n  = fail_q;
		head_n  = head_q;
		tail_n  = tail_q;
		if (req.valid && !term && !fail_q) begin
			if (do_octet) begin
				if (phase_q != PH_IGNORE) begin
					if (dig) begin
						if (dec_mul > {3'b000, OCTET_MAX}) begin
							fail_n = 1'b1;
						end else begin
							dec_n = dec_mul[8:0];
						end
					end else if (c == CH_DOT) begin
						oct_n   = {oct_q[23:0], dec_q[7:0]};
						dec_n   = '0;
						ocnt_n  = ocnt_q + 3'd1;
						phase_n = (ocnt_q + 3'd1 >= OCTETS) ? PH_IGNORE : PH_OCTET;
					end else begin
						fail_n = 1'b1;
					end
				end
			end else if (hx[4]) begin
				case (phase_q)
					PH_GROUP: begin
						if (hex_q > HEX_LIMIT) begin
							fail_n = 1'b1;
						end else begin
							hex_n = {hex_q[11:0], hx[3:0]};
							if (!dig || dec_q > OCTET_MAX) begin
								dec_n = DEC_BAD;
							end else begin
								dec_n = (dec_mul > {3'b000, OCTET_MAX}) ? DEC_BAD : dec_mul[8:0];
							end
						end
					end
					PH_START, PH_COLON, PH_GAP: begin
						if (gcnt_q >= (gap_q ? GAP_GROUPS : GROUPS)) begin
							fail_n = 1'b1;
						end else begin
							hex_n   = {12'h000, hx[3:0]};
							dec_n   = dig ? {5'b00000, c[3:0]} : DEC_BAD;
							phase_n = PH_GROUP;
						end
					end
					default: fail_n = 1'b1;
				endcase
			end else if (c == CH_COLON) begin
				case (phase_q)
					PH_START: phase_n = PH_LEAD;
					PH_LEAD: begin
						gap_n   = 1'b1;
						gpos_n  = '0;
						tail_n  = '0;
						phase_n = PH_GAP;
					end
					PH_GROUP: begin
						if (gap_q) begin
							tail_n = {tail_q[111:0], hex_q};
						end else begin
							head_n = {head_q[111:0], hex_q};
						end
						gcnt_n  = gcnt_q + 4'd1;
						phase_n = PH_COLON;
					end
					PH_COLON: begin
						if (!gap_q && gcnt_q < GROUPS) begin
							gap_n   = 1'b1;
							gpos_n  = gcnt_q[2:0];
							tail_n  = '0;
							phase_n = PH_GAP;
						end else begin
							fail_n = 1'b1;
						end
					end
					default: fail_n = 1'b1;
				endcase
			end else if (c == CH_DOT && phase_q == PH_GROUP && gap_q && gpos_q == 3'd0 &&
			             gcnt_q == 4'd1 && tail_q[15:0] == GROUP_MAP && dec_q <= OCTET_MAX) begin
				// embedded IPv4 after ::ffff:
				oct_n   = {23'h0, dec_q};
				ocnt_n  = 3'd1;
				dec_n   = '0;
				phase_n = PH_OCTET;
			end else begin
				fail_n = 1'b1;
			end
		end
		if (term) begin
			phase_n = PH_START;
			gcnt_n  = '0;
			gap_n   = 1'b0;
			gpos_n  = '0;
			hex_n   = '0;
			dec_n   = '0;
			oct_n   = '0;
			ocnt_n  = '0;
			fail_n  = 1'b0;
		end
	end

	// result assembly, only used on the terminator
	always_comb begin
		fin_cnt  = (phase_q == PH_GROUP) ? gcnt_q + 4'd1 : gcnt_q;
		fin_head = (phase_q == PH_GROUP && !gap_q) ? {head_q[111:0], hex_q} : head_q;
		fin_tail = (phase_q == PH_GROUP && gap_q) ? {tail_q[111:0], hex_q} : tail_q;
		v6_ok    = (phase_q == PH_GROUP || phase_q == PH_GAP) &&
		           (gap_q ? (fin_cnt <= GAP_GROUPS) : (fin_cnt == GROUPS));
		shamt    = GROUPS - {1'b0, gpos_q};
		head_sh  = (gpos_q == 3'd0) ? '0 : (fin_head << {shamt, 4'b0000});
		addr128  = gap_q ? (head_sh | fin_tail) : fin_head;
		oct_fin  = (phase_q == PH_IGNORE) ? oct_q : {oct_q[23:0], dec_q[7:0]};
		oct_ok   = (phase_q == PH_IGNORE) || (ocnt_q == OCTETS - 3'd1);
		if (fam_q) begin
			if (phase_q == PH_OCTET || phase_q == PH_IGNORE) begin
				fin_ok = oct_ok;
				fin_hi = '0;
				fin_lo = V4_MAP_LOW | {32'h0, oct_fin};
			end else begin
				fin_ok = v6_ok;
				fin_hi = addr128[127:64];
				fin_lo = addr128[63:0];
			end
		end else begin
			fin_ok = oct_ok;
			fin_hi = '0;
			fin_lo = {32'h0, oct_fin};
		end
		if (fail_q || !fin_ok) begin
			res.ok        = 1'b0;
			res.addr_high = '0;
			res.addr_low  = '0;
		end else begin
			res.ok        = 1'b1;
			res.addr_high = fin_hi;
			res.addr_low  = fin_lo;
		end
	end

	assign res_valid = term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fam_q   <= 1'b1;
			phase_q <= PH_START;
			gcnt_q  <= '0;
			gap_q   <= 1'b0;
			gpos_q  <= '0;
			hex_q   <= '0;
			dec_q   <= '0;
			oct_q   <= '0;
			ocnt_q  <= '0;
			fail_q  <= 1'b0;
		end else if (cfg_wen) begin
			// a mode change restarts the string
			fam_q   <= cfg_wdata;
			phase_q <= PH_START;
			gcnt_q  <= '0;
			gap_q   <= 1'b0;
			gpos_q  <= '0;
			hex_q   <= '0;
			dec_q   <= '0;
			oct_q   <= '0;
			ocnt_q  <= '0;
			fail_q  <= 1'b0;
		end else begin
			phase_q <= phase_n;
			gcnt_q  <= gcnt_n;
			gap_q   <= gap_n;
			gpos_q  <= gpos_n;
			hex_q   <= hex_n;
			dec_q   <= dec_n;
			oct_q   <= oct_n;
			ocnt_q  <= ocnt_n;
			fail_q  <= fail_n;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_n;
		tail_q <= tail_n;
	end

endmodule

FILE: rtl/core/ipap_out_reg.sv
// Result register of the parser: holds one result until the sink takes it.
// Depends on ipap_pkg.
module ipap_out_reg import ipap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        res_valid,
	input  ipap_res_t   res,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        ok,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	logic      valid_q;
	ipap_res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign ok        = res_q.ok;
	assign addr_high = res_q.addr_high;
	assign addr_low  = res_q.addr_low;

endmodule

FILE: rtl/core/ip_text_address_parser_top.sv
// IP address text parser, top level. Takes one character per cycle while
// in_stall is low, with no gaps needed between requests; a string ends with
// a zero character, which yields one result (ok, addr_high, addr_low) in the
// result register once it leaves the input register. The per-character state
// update lies between the input register and the result register. in_stall
// rises only while a terminator waits behind a result that the sink is stalling.
// Depends on ipap_pkg, ipap_in_stage, ipap_parse and ipap_out_reg.
module ip_text_address_parser_top import ipap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [63:0] addr_high,
	output logic [63:0] addr_low
);

	ipap_req_t req;
	ipap_res_t res;
	logic      res_valid;
	logic      out_busy;

	assign out_busy = out_valid && out_stall;

	ipap_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.char_code (char_code),
		.out_busy  (out_busy),
		.in_stall  (in_stall),
		.req       (req)
	);

	ipap_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.res_valid (res_valid),
		.res       (res)
	);

	ipap_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.ok        (ok),
		.addr_high (addr_high),
		.addr_low  (addr_low)
	);

endmodule

FILE: rtl/core/ipap_checker.sv
// Port-level checks for the IP address text parser, bound to the top level.
// Depends only on the top-level ports.
module ipap_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [63:0] addr_high,
	input logic [63:0] addr_low
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(addr_high) &&
		$stable(addr_low))
		else $error("stalled result changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> addr_high == 64'h0 && addr_low == 64'h0)
		else $error("failed result carries an address");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while result slot free");

endmodule

bind ip_text_address_parser_top ipap_checker u_ipap_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.ok        (ok),
	.addr_high (addr_high),
	.addr_low  (addr_low)
);
